[src/sha1_pkg.sv]
// Package: SHA-1 hash unit types, state codes and constants.
package sha1_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } st_t;

  localparam int NUM_WORDS   = 5;
  localparam int SCHED_DEPTH = 16;
  localparam int NUM_ROUNDS  = 80;
  localparam int LEN_POS     = 56;

  localparam word_t IV0 = 32'h67452301;
  localparam word_t IV1 = 32'hEFCDAB89;
  localparam word_t IV2 = 32'h98BADCFE;
  localparam word_t IV3 = 32'h10325476;
  localparam word_t IV4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

[src/sha1_hash_unit.sv]
// Top level: byte-serial SHA-1 hash unit with an iterative round engine.
//
//   channel | direction | payload   | meaning
//   in_     | in        | in_req_t  | one message byte or an empty closing request
//   out_    | out       | out_req_t | one digest word, h0 first, last flag on h4
//
// A byte that does not fill a block is stored while the unit stays idle. The byte that
// fills a block adds 80 rounds through the single round datapath and one chain add.
// A closing request writes padding one byte per cycle (up to two blocks), runs the
// compression per padded block, then presents the five digest words one per cycle.
// Reset is synchronous and restores the initial vector; no clearing pass is needed.
// in_ready is high only in idle; a stalled out_ready holds the current word.
module sha1_hash_unit
  import sha1_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  st_t         state_r, state_nxt;
  word_t       chain_r [NUM_WORDS];
  word_t       rnd_r   [NUM_WORDS];
  word_t       w_r     [SCHED_DEPTH];
  logic [5:0]  fill_r;
  logic [60:0] total_r;
  logic [6:0]  t_r;
  logic [2:0]  idx_r;
  logic        mark_r;
  logic        final_r;
  logic        last_r;

  logic        in_acc;
  logic        out_acc;
  logic        blk_full;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  word_t       f_w, k_w, tmp_w, w_new;
  word_t       a_w, b_w, c_w, d_w, e_w;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign blk_full = (fill_r == 6'd63);
  assign bit_len  = {total_r, 3'b000};
  assign len_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];

  always_comb begin
    if (!mark_r) begin
      pad_byte = PAD_MARK;
    end else if (final_r && (fill_r >= 6'(LEN_POS))) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // round function
  always_comb begin
    a_w = rnd_r[0];
    b_w = rnd_r[1];
    c_w = rnd_r[2];
    d_w = rnd_r[3];
    e_w = rnd_r[4];
    if (t_r < 7'd20) begin
      f_w = (b_w & c_w) | (~b_w & d_w);
      k_w = K0;
    end else if (t_r < 7'd40) begin
      f_w = b_w ^ c_w ^ d_w;
      k_w = K1;
    end else if (t_r < 7'd60) begin
      f_w = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
      k_w = K2;
    end else begin
      f_w = b_w ^ c_w ^ d_w;
      k_w = K3;
    end
    tmp_w = {a_w[26:0], a_w[31:27]} + f_w + e_w + k_w + w_r[0];
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte && blk_full) begin
            state_nxt = ST_ROUND;
          end else if (in_data.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (t_r == 7'(NUM_ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (mark_r || last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        if (blk_full) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_acc && (idx_r == 3'(NUM_WORDS - 1))) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    out_data.digest_word = chain_r[idx_r];
    out_data.word_last   = (idx_r == 3'(NUM_WORDS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r[0] <= IV0;
      chain_r[1] <= IV1;
      chain_r[2] <= IV2;
      chain_r[3] <= IV3;
      chain_r[4] <= IV4;
      fill_r     <= '0;
      total_r    <= '0;
      t_r        <= '0;
      idx_r      <= '0;
      mark_r     <= 1'b0;
      final_r    <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            last_r <= in_data.end_of_message;
            if (in_data.has_byte) begin
              w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_data.data_byte;
              fill_r  <= fill_r + 6'd1;
              total_r <= total_r + 61'd1;
              if (blk_full) begin
                for (int i = 0; i < NUM_WORDS; i++) rnd_r[i] <= chain_r[i];
                t_r <= '0;
              end
            end
          end
        end
        ST_ROUND: begin
          rnd_r[0] <= tmp_w;
          rnd_r[1] <= a_w;
          rnd_r[2] <= {b_w[1:0], b_w[31:2]};
          rnd_r[3] <= c_w;
          rnd_r[4] <= d_w;
          for (int i = 0; i < SCHED_DEPTH - 1; i++) w_r[i] <= w_r[i + 1];
          w_r[SCHED_DEPTH - 1] <= w_new;
          t_r <= t_r + 7'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < NUM_WORDS; i++) chain_r[i] <= chain_r[i] + rnd_r[i];
          if (mark_r) begin
            final_r <= 1'b1;
          end
        end
        ST_PAD: begin
          w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= pad_byte;
          fill_r <= fill_r + 6'd1;
          if (!mark_r) begin
            mark_r <= 1'b1;
            if (fill_r < 6'(LEN_POS)) begin
              final_r <= 1'b1;
            end
          end
          if (blk_full) begin
            for (int i = 0; i < NUM_WORDS; i++) rnd_r[i] <= chain_r[i];
            t_r <= '0;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (idx_r == 3'(NUM_WORDS - 1)) begin
              chain_r[0] <= IV0;
              chain_r[1] <= IV1;
              chain_r[2] <= IV2;
              chain_r[3] <= IV3;
              chain_r[4] <= IV4;
              idx_r   <= '0;
              fill_r  <= '0;
              total_r <= '0;
              mark_r  <= 1'b0;
              final_r <= 1'b0;
              last_r  <= 1'b0;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
